// ===== hw/rtl/lzw_pkg.sv =====
// Package for the LZW decoder: transaction payload types, operation and status codes.
// No dependencies.
`default_nettype none
package lzw_pkg;
   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_index;
      logic [2:0] status;
   } rsp_type;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_PUSH  = 2'd1;
   localparam logic [1:0] OP_PULL  = 2'd2;

   localparam logic [2:0] ST_PIXEL = 3'd0;
   localparam logic [2:0] ST_OK    = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_NEED  = 3'd3;
   localparam logic [2:0] ST_END   = 3'd4;
   localparam logic [2:0] ST_ERROR = 3'd5;

   // controller -> datapath commands
   typedef enum logic [3:0] {
      CMD_NONE, CMD_START, CMD_PUSH, CMD_POP, CMD_READ, CMD_KWK,
      CMD_WALK, CMD_FINISH, CMD_DROP
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic [7:0] data_byte;
   } ctl_type;

   // datapath -> controller status
   typedef struct packed {
      logic stack_empty;
      logic stack_full;
      logic buf_room;
      logic code_avail;
      logic is_clear;
      logic is_end;
      logic awaiting;
      logic first_bad;
      logic code_bad;
      logic is_kwk;
      logic walk_done;
      logic walk_err;
      logic [7:0] top_symbol;
      logic [7:0] code_low;
   } sts_type;
endpackage
`default_nettype wire

// ===== hw/rtl/lzw_datapath.sv =====
// LZW datapath: bit buffer, dictionary memory, expansion stack memory and code state.
// Depends on lzw_pkg.
`default_nettype none
module lzw_datapath #(
   parameter int DICT_ENTRIES = 4096,
   parameter int STACK_ENTRIES = 4096,
   parameter int BIT_BUFFER_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [3:0] min_code_size,
   input  wire lzw_pkg::ctl_type ctl,
   output lzw_pkg::sts_type sts
);
   import lzw_pkg::*;

   localparam int DW = $clog2(DICT_ENTRIES);
   localparam int SW = $clog2(STACK_ENTRIES);
   localparam int LW = $clog2(STACK_ENTRIES + 1);
   localparam int CW = $clog2(BIT_BUFFER_BITS + 1);

   logic [19:0] dict_mem [DICT_ENTRIES];
   logic [7:0]  stack_mem [STACK_ENTRIES];

   logic [BIT_BUFFER_BITS-1:0] buf_ff, buf_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [3:0]  width_ff, width_in;
   logic [12:0] nfc_ff, nfc_in;
   logic [12:0] lim_ff, lim_in;
   logic [11:0] prev_ff, prev_in;
   logic [7:0]  first_ff, first_in;
   logic        await_ff, await_in;
   logic [11:0] code_ff, code_in;   // code being expanded
   logic [11:0] walk_ff, walk_in;   // chain pointer
   logic [19:0] entry_ff;           // registered dictionary read
   logic [7:0]  top_ff;             // registered stack read

   logic [3:0]  root;
   logic [12:0] clear;
   logic [11:0] code_now;
   logic [12:0] code_x;
   logic [11:0] pre;
   logic        push_ok;
   logic        st_we, dict_we;
   logic [SW-1:0] st_wa;
   logic [7:0]  st_wd;
   logic [LW-1:0] rd_lvl;

   always_comb begin
      root = (min_code_size < 4'd2) ? 4'd2 : (min_code_size > 4'd8) ? 4'd8 : min_code_size;
      clear = 13'd1 << root;
      code_now = 12'(buf_ff & BIT_BUFFER_BITS'((64'd1 << width_ff) - 64'd1));
      code_x = {1'b0, code_now};
      pre = entry_ff[19:8];
      push_ok = lvl_ff < LW'(STACK_ENTRIES);
   end

   always_comb begin
      sts.stack_empty = lvl_ff == '0;
      sts.stack_full = !push_ok;
      sts.buf_room = (32'(cnt_ff) + 32'd8) <= 32'(BIT_BUFFER_BITS);
      sts.code_avail = {2'b0, cnt_ff} >= (CW + 2)'(width_ff);
      sts.is_clear = code_x == clear;
      sts.is_end = code_x == clear + 13'd1;
      sts.awaiting = await_ff;
      sts.first_bad = code_x > clear;
      sts.code_bad = code_x > nfc_ff;
      // code already consumed; compare the held copy
      sts.is_kwk = {1'b0, code_ff} == nfc_ff;
      sts.walk_done = {1'b0, walk_ff} < clear;
      sts.walk_err = !push_ok || ({1'b0, walk_ff} >= 13'(DICT_ENTRIES)) || pre == walk_ff;
      sts.top_symbol = top_ff;
      sts.code_low = code_now[7:0];
   end

   always_comb begin
      buf_in = buf_ff; cnt_in = cnt_ff; lvl_in = lvl_ff;
      width_in = width_ff; nfc_in = nfc_ff; lim_in = lim_ff;
      prev_in = prev_ff; first_in = first_ff; await_in = await_ff;
      code_in = code_ff; walk_in = walk_ff;
      st_we = 1'b0; st_wa = SW'(lvl_ff); st_wd = '0; dict_we = 1'b0;
      rd_lvl = lvl_ff - LW'(1);
      case (ctl.cmd)
         CMD_START: begin
            buf_in = '0; cnt_in = '0; lvl_in = '0;
            width_in = root + 4'd1; nfc_in = clear + 13'd2; lim_in = clear << 1;
            await_in = 1'b1;
         end
         CMD_PUSH: begin
            buf_in = buf_ff | (BIT_BUFFER_BITS'(ctl.data_byte) << cnt_ff);
            cnt_in = cnt_ff + CW'(8);
         end
         CMD_POP: lvl_in = lvl_ff - LW'(1);
         CMD_READ: begin
            // consume one code; clear resets dictionary, first code is a root
            buf_in = buf_ff >> width_ff;
            cnt_in = cnt_ff - CW'(width_ff);
            code_in = code_now;
            walk_in = code_now;
            if (sts.is_clear) begin
               width_in = root + 4'd1; nfc_in = clear + 13'd2; lim_in = clear << 1;
               lvl_in = '0; await_in = 1'b1;
            end else if (!sts.is_end && await_ff && !sts.first_bad) begin
               prev_in = code_now; first_in = code_now[7:0]; await_in = 1'b0;
            end
         end
         CMD_KWK: begin
            st_we = push_ok; st_wd = first_ff;
            lvl_in = lvl_ff + LW'(1);
            walk_in = prev_ff;
         end
         CMD_WALK: begin
            st_we = 1'b1; st_wd = entry_ff[7:0];
            lvl_in = lvl_ff + LW'(1);
            walk_in = pre;
         end
         CMD_FINISH: begin
            // push root, add entry if the dictionary has room, then pop the top as the pixel
            st_we = push_ok; st_wd = walk_ff[7:0];
            first_in = walk_ff[7:0];
            if ({1'b0, nfc_ff} < 13'(DICT_ENTRIES)) begin
               dict_we = 1'b1;
               nfc_in = nfc_ff + 13'd1;
               if (nfc_ff + 13'd1 >= lim_ff && {1'b0, lim_ff} < 14'(DICT_ENTRIES)) begin
                  lim_in = lim_ff << 1; width_in = width_ff + 4'd1;
               end
            end
            prev_in = code_ff;
         end
         CMD_DROP: lvl_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) stack_mem[st_wa] <= st_wd;
      if (dict_we) dict_mem[nfc_ff[DW-1:0]] <= {prev_ff, walk_ff[7:0]};
      entry_ff <= dict_mem[walk_in[DW-1:0]];
      top_ff <= (ctl.cmd == CMD_FINISH) ? walk_ff[7:0] : stack_mem[SW'(rd_lvl)];
      code_ff <= code_in; walk_ff <= walk_in;
      if (reset) begin
         buf_ff <= '0; cnt_ff <= '0; lvl_ff <= '0;
         width_ff <= 4'd9; nfc_ff <= 13'd258; lim_ff <= 13'd512;
         prev_ff <= '0; first_ff <= '0; await_ff <= 1'b1;
      end else begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in; lvl_ff <= lvl_in; width_ff <= width_in;
         nfc_ff <= nfc_in; lim_ff <= lim_in; prev_ff <= prev_in;
         first_ff <= first_in; await_ff <= await_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/lzw_controller.sv =====
// LZW controller: sequences each transaction as commands to the datapath.
// Depends on lzw_pkg.
`default_nettype none
module lzw_controller (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire lzw_pkg::req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output lzw_pkg::rsp_type rsp_data,
   output lzw_pkg::ctl_type ctl,
   input  wire lzw_pkg::sts_type sts
);
   import lzw_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_POP, S_READ, S_FETCH, S_WALK, S_TOP
   } state_type;

   state_type state_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic take;
   // set for the first fetch after a code is read: only then may KwKwK apply
   logic kwk_ff;

   assign req_ready = state_ff == S_IDLE && !rsp_valid_ff;
   assign take = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      ctl.data_byte = req_data.data_byte;
      ctl.cmd = CMD_NONE;
      case (state_ff)
         S_IDLE: if (take) begin
            if (req_data.operation == OP_START) ctl.cmd = CMD_START;
            else if (req_data.operation == OP_PUSH && sts.buf_room) ctl.cmd = CMD_PUSH;
         end
         S_POP: ctl.cmd = CMD_POP;
         S_READ: if (sts.code_avail) ctl.cmd = CMD_READ;
         S_FETCH: ctl.cmd = (kwk_ff && sts.is_kwk) ? CMD_KWK : CMD_NONE;
         S_WALK: begin
            if (sts.walk_done) ctl.cmd = sts.stack_full ? CMD_DROP : CMD_FINISH;
            else if (sts.walk_err) ctl.cmd = CMD_DROP;
            else ctl.cmd = CMD_WALK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0; rsp_ff <= '0; kwk_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (take) begin
               case (req_data.operation)
                  OP_START: begin rsp_ff <= '{8'd0, ST_OK}; rsp_valid_ff <= 1'b1; end
                  OP_PUSH: begin
                     rsp_ff <= '{8'd0, sts.buf_room ? ST_OK : ST_FULL};
                     rsp_valid_ff <= 1'b1;
                  end
                  OP_PULL: state_ff <= sts.stack_empty ? S_READ : S_POP;
                  default: begin rsp_ff <= '{8'd0, ST_ERROR}; rsp_valid_ff <= 1'b1; end
               endcase
            end
            S_POP: begin
               rsp_ff <= '{sts.top_symbol, ST_PIXEL}; rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_READ: begin
               if (!sts.code_avail) begin
                  rsp_ff <= '{8'd0, ST_NEED}; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end else if (sts.is_clear) begin
                  state_ff <= S_READ;
               end else if (sts.is_end) begin
                  rsp_ff <= '{8'd0, ST_END}; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end else if (sts.awaiting) begin
                  if (sts.first_bad) rsp_ff <= '{8'd0, ST_ERROR};
                  else rsp_ff <= '{sts.code_low, ST_PIXEL};
                  rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end else if (sts.code_bad) begin
                  rsp_ff <= '{8'd0, ST_ERROR}; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end else begin
                  kwk_ff <= 1'b1;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               kwk_ff <= 1'b0;
               state_ff <= S_WALK;  // dictionary read of chain head settles
            end
            S_WALK: begin
               if (sts.walk_done && !sts.stack_full) begin
                  state_ff <= S_TOP;
               end else if (sts.walk_done || sts.walk_err) begin
                  rsp_ff <= '{8'd0, ST_ERROR}; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_FETCH;
               end
            end
            S_TOP: begin
               // root symbol is the pixel; its push and pop cancel on the stack
               rsp_ff <= '{sts.top_symbol, ST_PIXEL}; rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/lzw_variable_width_decoder.sv =====
// Top level of the GIF-style LZW decoder: controller plus datapath.
// Depends on lzw_pkg, lzw_controller and lzw_datapath.
//
// GIF LZW decoder, codes packed LSB first, width growing from min_code_size+1
// (min_code_size clamped to 2..8) to 12 bits. A transaction carries an
// operation: start (reset dictionary, empty bit buffer), push (append one
// byte to a BIT_BUFFER_BITS buffer, or report buffer full), or pull (return
// one pixel, or a need-data, end or error status). Each transaction returns
// exactly one response. A pull that pops the expansion stack returns the
// registered stack memory read. A pull of the first code after a start or
// clear returns that code as the pixel. A pull that decodes a code walks the
// dictionary chain, for each symbol a registered dictionary read, then a
// stack push; later pulls of that string pop the stack. Clear codes are
// skipped in line. The dictionary and stack memories need no clearing pass.
// min_code_size is written through csr_ and must only change while the block
// is idle.
`default_nettype none
module lzw_variable_width_decoder #(
   parameter int DICT_ENTRIES = 4096,
   parameter int STACK_ENTRIES = 4096,
   parameter int BIT_BUFFER_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_enable,
   input  wire logic [3:0] csr_write_data,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire lzw_pkg::req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output lzw_pkg::rsp_type rsp_data
);
   import lzw_pkg::*;

   logic [3:0] min_code_size_ff;
   ctl_type ctl;
   sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) min_code_size_ff <= 4'd8;
      else if (csr_write_enable) min_code_size_ff <= csr_write_data;
   end

   lzw_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .ctl, .sts
   );

   lzw_datapath #(
      .DICT_ENTRIES(DICT_ENTRIES), .STACK_ENTRIES(STACK_ENTRIES),
      .BIT_BUFFER_BITS(BIT_BUFFER_BITS)
   ) u_dp (
      .clock, .reset, .min_code_size(min_code_size_ff), .ctl, .sts
   );
endmodule
`default_nettype wire
